@@ rtl/tsfj_pkg.sv @@
// ----------------------------------------------------------------------------
// tsfj_pkg: shared types and constants of the three-stream frame joiner
// Table geometry, field widths, opcodes and the word passed front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package tsfj_pkg;
   localparam int TableEntries = 16;
   localparam int HandleBits   = 16;
   localparam int SlotBits     = $clog2(TableEntries);
   localparam int CountBits    = $clog2(TableEntries + 1);
   localparam int QueueDepth   = 2;

   localparam logic [1:0] OP_VIDEO = 2'd0;
   localparam logic [1:0] OP_DEPTH = 2'd1;
   localparam logic [1:0] OP_POSE  = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   localparam logic CSR_DEPTH_REQUIRED = 1'b0;
   localparam logic CSR_STALE_TIMEOUT  = 1'b1;

   typedef struct packed {
      logic [1:0]            op;
      logic [31:0]           seq;
      logic [63:0]           stamp;
      logic [HandleBits-1:0] handle;
      logic [31:0]           now;
   } cmd_type;
endpackage
`default_nettype wire

@@ rtl/tsfj_front.sv @@
// ----------------------------------------------------------------------------
// tsfj_front: command intake and queue
// Accepts request words and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module tsfj_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire  [1:0]            req_op,
   input  wire  [31:0]           req_frame_seq,
   input  wire  [63:0]           req_capture_time_us,
   input  wire  [15:0]           req_payload_handle,
   input  wire  [31:0]           req_now_time,
   output logic                  q_valid,
   output tsfj_pkg::cmd_type     q_cmd,
   input  wire                   q_pop
);
   import tsfj_pkg::*;

   cmd_type   mem_ff [QueueDepth];
   logic      rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push;

   assign busy    = (cnt_ff == 2'(QueueDepth));
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd   = mem_ff[rd_ff];

   // advance pointers and count
   always_comb begin
      rd_in  = rd_ff ^ q_pop;
      wr_in  = wr_ff ^ push;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0; wr_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in;
      end
   end

   // store the incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= '{op: req_op, seq: req_frame_seq, stamp: req_capture_time_us,
                            handle: req_payload_handle[HandleBits-1:0], now: req_now_time};
      end
   end
endmodule
`default_nettype wire

@@ rtl/tsfj_back.sv @@
// ----------------------------------------------------------------------------
// tsfj_back: pending table and delivery sequencer
// Matches arrivals, evicts the oldest on a full table and sweeps stale entries.
// ----------------------------------------------------------------------------
`default_nettype none
module tsfj_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_valid,
   input  tsfj_pkg::cmd_type     q_cmd,
   output logic                  q_pop,
   input  wire                   depth_required,
   input  wire  [15:0]           stale_timeout,
   output logic                  rsp_valid,
   output logic [31:0]           rsp_bundle_seq,
   output logic [63:0]           rsp_bundle_time_us,
   output logic                  rsp_has_video,
   output logic                  rsp_has_depth,
   output logic                  rsp_has_pose,
   output logic [15:0]           rsp_video_handle,
   output logic [15:0]           rsp_depth_handle,
   output logic [15:0]           rsp_pose_handle,
   output logic                  rsp_partial,
   output logic                  rsp_last,
   output logic [4:0]            rsp_pending_count,
   output logic [31:0]           rsp_completed_count
);
   import tsfj_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_EVICT, S_UPDATE, S_CHECK, S_SWEEP, S_EMIT
   } state_type;

   // table storage
   logic                  valid_ff [TableEntries];
   logic [31:0]           seq_ff   [TableEntries];
   logic [31:0]           first_ff [TableEntries];
   logic [2:0]            pres_ff  [TableEntries];
   logic [2:0][HandleBits-1:0] hnd_ff [TableEntries];
   logic [63:0]           stp_ff   [TableEntries][3];

   state_type             state_ff;
   cmd_type               cmd_ff;
   logic [SlotBits:0]     idx_ff;
   logic [SlotBits-1:0]   slot_ff, best_ff;
   logic                  found_ff, free_ok_ff, have_ff, evict_ff;
   logic [31:0]           best_age_ff, best_seq_ff;
   logic [TableEntries-1:0] stale_ff;
   logic [31:0]           done_ff;

   // one pending delivery held until the item ends (to mark last)
   logic                  hold_ff;
   logic                  hold_part_ff;
   logic [31:0]           hold_seq_ff;
   logic [63:0]           hold_tm_ff;
   logic [2:0]            hold_pres_ff;
   logic [HandleBits-1:0] hold_h_ff [3];

   logic [SlotBits-1:0]   cur;
   logic [31:0]           age;
   logic [2:0]            comp_bit;
   logic [1:0]            comp;
   logic [2:0]            newp;
   logic [CountBits-1:0]  pending;
   logic [CountBits-1:0]  stale_cnt;

   // bundle stamp source: video first, then pose, then depth
   function automatic logic [1:0] stamp_src(input logic [2:0] p);
      if (p[0]) return 2'd0;
      else if (p[2]) return 2'd2;
      else return 2'd1;
   endfunction

   assign cur = idx_ff[SlotBits-1:0];
   assign age = cmd_ff.now - first_ff[cur];
   assign comp = (cmd_ff.op == OP_VIDEO) ? 2'd0 : (cmd_ff.op == OP_DEPTH) ? 2'd1 : 2'd2;
   assign comp_bit = 3'b001 << comp;
   assign newp = pres_ff[slot_ff];
   assign q_pop = (state_ff == S_IDLE) && q_valid;

   // count valid entries and entries still to sweep
   always_comb begin
      pending = '0;
      stale_cnt = '0;
      for (int i = 0; i < TableEntries; i++) begin
         pending = pending + CountBits'(valid_ff[i]);
         stale_cnt = stale_cnt + CountBits'(stale_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
         hold_ff   <= 1'b0;
         done_ff   <= '0;
         for (int i = 0; i < TableEntries; i++) valid_ff[i] <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cmd_ff      <= q_cmd;
                  idx_ff      <= '0;
                  found_ff    <= 1'b0;
                  free_ok_ff  <= 1'b0;
                  have_ff     <= 1'b0;
                  evict_ff    <= 1'b0;
                  best_age_ff <= '0;
                  best_ff     <= '0;
                  if (q_cmd.op == OP_TICK) begin
                     state_ff <= S_SWEEP;
                     for (int i = 0; i < TableEntries; i++)
                        stale_ff[i] <= valid_ff[i] &&
                           ((q_cmd.now - first_ff[i]) >= {16'd0, stale_timeout});
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            // walk the table: match, first free, oldest
            S_SCAN: begin
               if (valid_ff[cur] && seq_ff[cur] == cmd_ff.seq && !found_ff) begin
                  found_ff <= 1'b1; slot_ff <= cur;
               end
               if (!valid_ff[cur] && !free_ok_ff) begin
                  free_ok_ff <= 1'b1; best_ff <= cur;
               end
               if (valid_ff[cur] && (cur == '0 || age > best_age_ff) && !free_ok_ff
                   && !(!valid_ff[cur])) begin
                  best_age_ff <= age;
                  best_ff     <= cur;
               end
               if (cur == SlotBits'(TableEntries - 1)) state_ff <= S_EVICT;
               idx_ff <= idx_ff + 1'b1;
            end
            // create an entry, evicting the oldest when full
            S_EVICT: begin
               if (!found_ff) begin
                  slot_ff          <= best_ff;
                  valid_ff[best_ff] <= 1'b1;
                  seq_ff[best_ff]   <= cmd_ff.seq;
                  first_ff[best_ff] <= cmd_ff.now;
                  pres_ff[best_ff]  <= 3'b000;
                  if (!free_ok_ff) begin
                     evict_ff     <= 1'b1;
                     hold_ff      <= 1'b1;
                     hold_part_ff <= 1'b1;
                     hold_seq_ff  <= seq_ff[best_ff];
                     hold_pres_ff <= pres_ff[best_ff];
                     hold_tm_ff   <= (pres_ff[best_ff] == 3'b000) ? 64'd0 :
                                     stp_ff[best_ff][stamp_src(pres_ff[best_ff])];
                     for (int c = 0; c < 3; c++)
                        hold_h_ff[c] <= pres_ff[best_ff][c] ? hnd_ff[best_ff][c] : '0;
                  end
               end
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               pres_ff[slot_ff]       <= pres_ff[slot_ff] | comp_bit;
               hnd_ff[slot_ff][comp]  <= cmd_ff.handle;
               stp_ff[slot_ff][comp]  <= cmd_ff.stamp;
               state_ff <= S_CHECK;
            end
            // deliver a complete bundle
            S_CHECK: begin
               if (newp[0] && newp[2] && (!depth_required || newp[1])) begin
                  valid_ff[slot_ff] <= 1'b0;
                  done_ff <= done_ff + 32'd1;
                  hold_part_ff <= 1'b0;
                  hold_seq_ff  <= seq_ff[slot_ff];
                  hold_pres_ff <= newp;
                  hold_tm_ff   <= stp_ff[slot_ff][stamp_src(newp)];
                  for (int c = 0; c < 3; c++)
                     hold_h_ff[c] <= newp[c] ? hnd_ff[slot_ff][c] : '0;
                  if (evict_ff) begin
                     // emit eviction now, keep completion held
                     rsp_valid          <= 1'b1;
                     rsp_last           <= 1'b0;
                     rsp_partial        <= 1'b1;
                     rsp_bundle_seq     <= hold_seq_ff;
                     rsp_bundle_time_us <= hold_tm_ff;
                     {rsp_has_pose, rsp_has_depth, rsp_has_video} <= hold_pres_ff;
                     rsp_video_handle   <= 16'(hold_h_ff[0]);
                     rsp_depth_handle   <= 16'(hold_h_ff[1]);
                     rsp_pose_handle    <= 16'(hold_h_ff[2]);
                     rsp_pending_count  <= 5'(pending - 1'b1);
                     rsp_completed_count <= done_ff + 32'd1;
                  end
                  hold_ff  <= 1'b1;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_EMIT;
               end
            end
            // pick the stale entry with the lowest sequence, one per pass
            S_SWEEP: begin
               if (idx_ff[SlotBits]) begin
                  if (have_ff) begin
                     stale_ff[best_ff] <= 1'b0;
                     valid_ff[best_ff] <= 1'b0;
                     if (hold_ff) begin
                        rsp_valid          <= 1'b1;
                        rsp_last           <= 1'b0;
                        rsp_partial        <= 1'b1;
                        rsp_bundle_seq     <= hold_seq_ff;
                        rsp_bundle_time_us <= hold_tm_ff;
                        {rsp_has_pose, rsp_has_depth, rsp_has_video} <= hold_pres_ff;
                        rsp_video_handle   <= 16'(hold_h_ff[0]);
                        rsp_depth_handle   <= 16'(hold_h_ff[1]);
                        rsp_pose_handle    <= 16'(hold_h_ff[2]);
                        rsp_completed_count <= done_ff;
                     end
                     hold_ff      <= 1'b1;
                     hold_part_ff <= 1'b1;
                     hold_seq_ff  <= seq_ff[best_ff];
                     hold_pres_ff <= pres_ff[best_ff];
                     hold_tm_ff   <= (pres_ff[best_ff] == 3'b000) ? 64'd0 :
                                     stp_ff[best_ff][stamp_src(pres_ff[best_ff])];
                     for (int c = 0; c < 3; c++)
                        hold_h_ff[c] <= pres_ff[best_ff][c] ? hnd_ff[best_ff][c] : '0;
                     idx_ff <= '0;
                  end else begin
                     state_ff <= S_EMIT;
                  end
               end else begin
                  if (stale_ff[cur] && (idx_ff == '0 || !have_ff ||
                                        seq_ff[cur] < best_seq_ff)) begin
                     have_ff     <= 1'b1;
                     best_ff     <= cur;
                     best_seq_ff <= seq_ff[cur];
                  end else if (idx_ff == '0) begin
                     have_ff <= 1'b0;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            // flush the held word as last, with final counts
            S_EMIT: begin
               if (hold_ff) begin
                  rsp_valid          <= 1'b1;
                  rsp_last           <= 1'b1;
                  rsp_partial        <= hold_part_ff;
                  rsp_bundle_seq     <= hold_seq_ff;
                  rsp_bundle_time_us <= hold_tm_ff;
                  {rsp_has_pose, rsp_has_depth, rsp_has_video} <= hold_pres_ff;
                  rsp_video_handle   <= 16'(hold_h_ff[0]);
                  rsp_depth_handle   <= 16'(hold_h_ff[1]);
                  rsp_pose_handle    <= 16'(hold_h_ff[2]);
                  rsp_completed_count <= done_ff;
               end
               hold_ff  <= 1'b0;
               state_ff <= S_EMIT == state_ff ? S_IDLE : S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         // pending count is the count after the whole item; entries still
         // to sweep are already gone from it
         if (state_ff == S_SWEEP) rsp_pending_count <= 5'(pending - stale_cnt);
         else if (state_ff != S_CHECK) rsp_pending_count <= 5'(pending);
      end
   end
endmodule
`default_nettype wire

@@ rtl/three_stream_frame_joiner.sv @@
// An arrival scans every table slot for a match, a free slot and the oldest entry.
// A sweep rescans the table for each stale entry that it removes, lowest sequence first.
// Results come one per cycle-strobe; the receiver cannot stall.
// A two-word queue lets start be taken while the table engine works.
// Synchronous reset empties the table, zeroes the count and restores registers.
// ----------------------------------------------------------------------------
// three_stream_frame_joiner: top level
// Joins video, depth and pose components by frame sequence number.
// ----------------------------------------------------------------------------
`default_nettype none
module three_stream_frame_joiner (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_op,
   input  wire  [31:0] req_frame_seq,
   input  wire  [63:0] req_capture_time_us,
   input  wire  [15:0] req_payload_handle,
   input  wire  [31:0] req_now_time,
   input  wire         csr_write,
   input  wire         csr_index,
   input  wire  [15:0] csr_wdata,
   output logic        rsp_valid,
   output logic [31:0] rsp_bundle_seq,
   output logic [63:0] rsp_bundle_time_us,
   output logic        rsp_has_video,
   output logic        rsp_has_depth,
   output logic        rsp_has_pose,
   output logic [15:0] rsp_video_handle,
   output logic [15:0] rsp_depth_handle,
   output logic [15:0] rsp_pose_handle,
   output logic        rsp_partial,
   output logic        rsp_last,
   output logic [4:0]  rsp_pending_count,
   output logic [31:0] rsp_completed_count
);
   import tsfj_pkg::*;

   logic        depth_req_ff;
   logic [15:0] timeout_ff;
   logic        q_valid, q_pop;
   cmd_type     q_cmd;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_req_ff <= 1'b1;
         timeout_ff   <= 16'd100;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DEPTH_REQUIRED: depth_req_ff <= csr_wdata[0];
            CSR_STALE_TIMEOUT:  timeout_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   tsfj_front u_front (
      .clock, .reset, .start, .busy,
      .req_op, .req_frame_seq, .req_capture_time_us, .req_payload_handle, .req_now_time,
      .q_valid, .q_cmd, .q_pop
   );

   tsfj_back u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_pop,
      .depth_required(depth_req_ff), .stale_timeout(timeout_ff),
      .rsp_valid, .rsp_bundle_seq, .rsp_bundle_time_us,
      .rsp_has_video, .rsp_has_depth, .rsp_has_pose,
      .rsp_video_handle, .rsp_depth_handle, .rsp_pose_handle,
      .rsp_partial, .rsp_last, .rsp_pending_count, .rsp_completed_count
   );
endmodule
`default_nettype wire
